// ===== hw/rtl/seth_pkg.sv =====
// shared types, constants and codes of the edge trigger with holdoff
// no dependencies; every other file takes names from here by scope
package seth_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int THR_BITS      = 16;
    localparam int CMP_BITS      = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
    localparam int FRAME_BITS    = 48;
    localparam int OUT_BITS      = 48;
    localparam int HOLD_BITS     = 24;
    localparam int RATE_BITS     = 24;
    localparam int FREQ_BITS     = 32;
    localparam int MODE_BITS     = 2;
    localparam int CMD_BITS      = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;
    localparam int SUM_BITS      = FREQ_BITS + 4;
    localparam int NUM_BITS      = (FRAME_BITS > SUM_BITS) ? FRAME_BITS : SUM_BITS;
    localparam int DIV_CNT_BITS  = $clog2(NUM_BITS);
    localparam int QDEPTH        = 4;
    localparam int QPTR_BITS     = $clog2(QDEPTH);

    localparam logic [CMD_BITS-1:0] CMD_SAMPLE = CMD_BITS'(0);
    localparam logic [CMD_BITS-1:0] CMD_RUN    = CMD_BITS'(1);
    localparam logic [CMD_BITS-1:0] CMD_STOP   = CMD_BITS'(2);

    localparam logic [MODE_BITS-1:0] MODE_SINGLE = MODE_BITS'(2);

    localparam logic [CFG_IDX_BITS-1:0] REG_THR_HIGH = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_THR_LOW  = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_RISING   = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLDOFF  = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE     = CFG_IDX_BITS'(4);
    localparam logic [CFG_IDX_BITS-1:0] REG_RATE     = CFG_IDX_BITS'(5);

    localparam logic [HOLD_BITS-1:0] HOLDOFF_RESET = HOLD_BITS'(1);
    localparam logic [RATE_BITS-1:0] RATE_RESET    = RATE_BITS'(48000);
    localparam logic [SUM_BITS-1:0]  AVG_DIVISOR   = SUM_BITS'(10);
    localparam logic [SUM_BITS-1:0]  AVG_ROUND     = SUM_BITS'(5);

    typedef struct packed {
        logic signed [THR_BITS-1:0] thr_high;
        logic signed [THR_BITS-1:0] thr_low;
        logic                       rising;
        logic [HOLD_BITS-1:0]       holdoff;
        logic [MODE_BITS-1:0]       mode;
        logic [RATE_BITS-1:0]       rate;
    } t_cfg;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        logic [FRAME_BITS-1:0] interval;
        logic                  calc;
        logic                  stopped;
    } t_trig;

endpackage

// ===== hw/rtl/seth_front.sv =====
// front end: takes requests, counts frames, runs holdoff and the arm/fire detector
// depends on seth_pkg; pushes one trigger record per firing into the queue
module seth_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  seth_pkg::t_cfg                       i_cfg,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [seth_pkg::CMD_BITS-1:0]        i_cmd,
    input  logic signed [seth_pkg::SAMPLE_BITS-1:0] i_sample_value,
    input  logic                                 i_q_full,
    output logic                                 o_push,
    output seth_pkg::t_trig                      o_trig
);

    logic                                r_armed, n_armed;
    logic                                r_running, n_running;
    logic [seth_pkg::HOLD_BITS-1:0]      r_hold, n_hold;
    logic [seth_pkg::FRAME_BITS-1:0]     r_frame, n_frame;
    logic [seth_pkg::FRAME_BITS-1:0]     r_prev, n_prev;
    logic                                r_have, n_have;

    logic                                accept;
    logic                                fire;
    logic signed [seth_pkg::CMP_BITS-1:0] v_ext, hi_ext, lo_ext;
    logic [seth_pkg::FRAME_BITS-1:0]     interval;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    assign v_ext  = seth_pkg::CMP_BITS'(i_sample_value);
    assign hi_ext = seth_pkg::CMP_BITS'(i_cfg.thr_high);
    assign lo_ext = seth_pkg::CMP_BITS'(i_cfg.thr_low);

    always_comb begin
        n_armed   = r_armed;
        n_running = r_running;
        n_hold    = r_hold;
        n_frame   = r_frame;
        n_prev    = r_prev;
        n_have    = r_have;
        fire      = 1'b0;
        if (accept) begin
            unique case (i_cmd)
                seth_pkg::CMD_RUN: begin
                    n_running = 1'b1;
                end
                seth_pkg::CMD_STOP: begin
                    n_running = 1'b0;
                end
                seth_pkg::CMD_SAMPLE: begin
                    n_frame = r_frame + seth_pkg::FRAME_BITS'(1);
                    if (r_hold != '0) begin
                        n_hold = r_hold - seth_pkg::HOLD_BITS'(1);
                    end else if (r_running) begin
                        if (i_cfg.rising) begin
                            if (!r_armed) begin
                                n_armed = (v_ext < lo_ext);
                            end else if (v_ext >= hi_ext) begin
                                fire = 1'b1;
                            end
                        end else begin
                            if (!r_armed) begin
                                n_armed = (v_ext > hi_ext);
                            end else if (v_ext <= lo_ext) begin
                                fire = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (fire) begin
            n_armed = 1'b0;
            n_prev  = r_frame;
            n_have  = 1'b1;
            n_hold  = (i_cfg.holdoff == '0) ? '0
                                            : i_cfg.holdoff - seth_pkg::HOLD_BITS'(1);
            if (i_cfg.mode == seth_pkg::MODE_SINGLE) begin
                n_running = 1'b0;
            end
        end
    end

    assign interval        = r_frame - r_prev;
    assign o_push          = fire;
    assign o_trig.frame    = r_frame;
    assign o_trig.interval = interval;
    assign o_trig.calc     = r_have && (interval != '0);
    assign o_trig.stopped  = (i_cfg.mode == seth_pkg::MODE_SINGLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= 1'b0;
            r_running <= 1'b1;
            r_hold    <= '0;
            r_frame   <= '0;
            r_prev    <= '0;
            r_have    <= 1'b0;
        end else begin
            r_armed   <= n_armed;
            r_running <= n_running;
            r_hold    <= n_hold;
            r_frame   <= n_frame;
            r_prev    <= n_prev;
            r_have    <= n_have;
        end
    end

    a_fire_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> !r_armed && r_have && (r_prev == $past(r_frame)))
        else $error("trigger record not followed by disarm and frame capture");

endmodule

// ===== hw/rtl/seth_fifo.sv =====
// short queue of trigger records between the front end and the frequency back end
// depends on seth_pkg for the record type and depth
module seth_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  seth_pkg::t_trig i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output seth_pkg::t_trig o_data
);

    seth_pkg::t_trig                  r_mem [seth_pkg::QDEPTH];
    logic [seth_pkg::QPTR_BITS-1:0]   r_wr, r_rd;
    logic [seth_pkg::QPTR_BITS:0]     r_count;

    assign o_full  = (r_count == (seth_pkg::QPTR_BITS + 1)'(seth_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + seth_pkg::QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + seth_pkg::QPTR_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (seth_pkg::QPTR_BITS + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (seth_pkg::QPTR_BITS + 1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("trigger queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("trigger queue underflow");

endmodule

// ===== hw/rtl/seth_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on seth_pkg for the operand width; divides the scaled rate by the trigger interval
module seth_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [seth_pkg::NUM_BITS-1:0] i_num,
    input  logic [seth_pkg::NUM_BITS-1:0] i_den,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [seth_pkg::NUM_BITS-1:0] o_quo
);

    logic                              r_busy, r_done;
    logic [seth_pkg::DIV_CNT_BITS-1:0] r_cnt;
    logic [seth_pkg::NUM_BITS-1:0]     r_rem, r_quo, r_den;
    logic [seth_pkg::NUM_BITS:0]       shifted;
    logic [seth_pkg::NUM_BITS+1:0]     diff;
    logic                              borrow;

    assign shifted = {r_rem, r_quo[seth_pkg::NUM_BITS-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_den};
    assign borrow  = diff[seth_pkg::NUM_BITS+1];

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= borrow ? shifted[seth_pkg::NUM_BITS-1:0]
                            : diff[seth_pkg::NUM_BITS-1:0];
            r_quo <= {r_quo[seth_pkg::NUM_BITS-2:0], !borrow};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= seth_pkg::DIV_CNT_BITS'(seth_pkg::NUM_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - seth_pkg::DIV_CNT_BITS'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/seth_back.sv =====
// back end: frequency estimate, 0.7/0.3 smoothing and the result register
// depends on seth_pkg and seth_div; takes trigger records from the queue
module seth_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [seth_pkg::RATE_BITS-1:0]  i_rate,
    input  logic                            i_q_empty,
    input  seth_pkg::t_trig                 i_q_data,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [seth_pkg::OUT_BITS-1:0]   o_trigger_frame,
    output logic [seth_pkg::OUT_BITS-1:0]   o_trigger_interval,
    output logic [seth_pkg::FREQ_BITS-1:0]  o_freq_smoothed,
    output logic                            o_now_stopped
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DIV_EST = 3'd1;
    localparam logic [2:0] ST_SUM     = 3'd2;
    localparam logic [2:0] ST_QA      = 3'd3;
    localparam logic [2:0] ST_QB      = 3'd4;
    localparam logic [2:0] ST_QC      = 3'd5;
    localparam logic [2:0] ST_FIX     = 3'd6;
    localparam logic [2:0] ST_OUT     = 3'd7;

    logic [2:0]                       r_state, n_state;
    seth_pkg::t_trig                  r_entry, n_entry;
    logic [seth_pkg::FREQ_BITS-1:0]   r_avg, n_avg;
    logic [seth_pkg::FREQ_BITS-1:0]   r_est, n_est;
    logic [seth_pkg::SUM_BITS-1:0]    r_sum, n_sum;
    logic [seth_pkg::SUM_BITS-1:0]    r_q, n_q;
    logic [seth_pkg::SUM_BITS-1:0]    r_q10, n_q10;
    logic                             r_o_valid, n_o_valid;
    logic [seth_pkg::OUT_BITS-1:0]    r_o_frame, r_o_interval;
    logic [seth_pkg::FREQ_BITS-1:0]   r_o_freq;
    logic                             r_o_stopped;

    logic                             load;
    logic                             out_free;
    logic                             div_start;
    logic [seth_pkg::NUM_BITS-1:0]    div_num, div_den, div_quo;
    logic                             div_busy, div_done;
    logic [seth_pkg::FREQ_BITS-1:0]   est_sat;
    logic [seth_pkg::SUM_BITS-1:0]    q_part, q_step, q_tail, avg_rem;

    seth_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign out_free = !r_o_valid || i_ready;
    assign est_sat  = (div_quo[seth_pkg::NUM_BITS-1:seth_pkg::FREQ_BITS] != '0)
                      ? '1 : div_quo[seth_pkg::FREQ_BITS-1:0];
    assign div_num  = seth_pkg::NUM_BITS'({i_rate, 8'h00})
                      + seth_pkg::NUM_BITS'(i_q_data.interval >> 1);
    assign div_den  = seth_pkg::NUM_BITS'(i_q_data.interval);

    // divide by ten: multiply by 0.8 with shifts and adds, then shift by three;
    // the quotient is at most one low and the remainder check puts it right
    assign q_part  = (r_sum >> 1) + (r_sum >> 2);
    assign q_step  = r_q + (r_q >> 8);
    assign q_tail  = (r_q + (r_q >> 32)) >> 3;
    assign avg_rem = r_sum - r_q10;

    always_comb begin
        n_state   = r_state;
        n_entry   = r_entry;
        n_avg     = r_avg;
        n_est     = r_est;
        n_sum     = r_sum;
        n_q       = r_q;
        n_q10     = r_q10;
        o_pop     = 1'b0;
        load      = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_entry = i_q_data;
                    if (i_q_data.calc) begin
                        div_start = 1'b1;
                        n_state   = ST_DIV_EST;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_DIV_EST: begin
                if (div_done) begin
                    if (r_avg == '0) begin
                        n_avg   = est_sat;
                        n_state = ST_OUT;
                    end else begin
                        n_est   = est_sat;
                        n_state = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                // 7 * avg + 3 * est + 5
                n_sum = seth_pkg::SUM_BITS'({r_avg, 3'b000}) - seth_pkg::SUM_BITS'(r_avg)
                        + seth_pkg::SUM_BITS'({r_est, 1'b0}) + seth_pkg::SUM_BITS'(r_est)
                        + seth_pkg::AVG_ROUND;
                n_state = ST_QA;
            end
            ST_QA: begin
                n_q     = q_part + (q_part >> 4);
                n_state = ST_QB;
            end
            ST_QB: begin
                n_q     = q_step + (q_step >> 16);
                n_state = ST_QC;
            end
            ST_QC: begin
                n_q     = q_tail;
                n_q10   = (q_tail << 3) + (q_tail << 1);
                n_state = ST_FIX;
            end
            ST_FIX: begin
                n_avg   = r_q[seth_pkg::FREQ_BITS-1:0]
                          + seth_pkg::FREQ_BITS'(avg_rem >= seth_pkg::AVG_DIVISOR);
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
        endcase
        n_o_valid = r_o_valid;
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end
        if (load) begin
            n_o_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_est   <= n_est;
        r_sum   <= n_sum;
        r_q     <= n_q;
        r_q10   <= n_q10;
        if (load) begin
            r_o_frame    <= seth_pkg::OUT_BITS'(r_entry.frame);
            r_o_interval <= r_entry.calc ? seth_pkg::OUT_BITS'(r_entry.interval) : '0;
            r_o_freq     <= r_avg;
            r_o_stopped  <= r_entry.stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_avg     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_avg     <= n_avg;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_trigger_frame    = r_o_frame;
    assign o_trigger_interval = r_o_interval;
    assign o_freq_smoothed    = r_o_freq;
    assign o_now_stopped      = r_o_stopped;

    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_OUT) |-> !div_busy)
        else $error("divider running outside a divide step");

endmodule

// ===== hw/rtl/scope_edge_trigger_holdoff.sv =====
// top level of the oscilloscope edge trigger with hysteresis and holdoff
// depends on seth_pkg, seth_front, seth_fifo and seth_back; holds the settings registers
//
// Each request is a sample or a run/stop command. While the queue has room the front end
// takes one request per clock and does not wait on the frequency arithmetic: samples
// advance the 48-bit frame counter and count down holdoff or arm or fire the trigger in
// the same cycle. Every firing drops a record into a four-entry queue. The back end
// turns each record into a result: one without a usable interval goes out directly;
// otherwise a 48-step divider forms round(rate * 256 / interval), and when an average
// exists a sum, shift-and-add steps and a remainder fix divide by ten for the 0.7/0.3
// blend. A result waits in the output register until taken. Input ready drops only
// while the queue holds four triggers not yet taken by the back end. Settings are to be
// written through the plain write port while the block is idle, which is not enforced.
module scope_edge_trigger_holdoff (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [seth_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [seth_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [seth_pkg::CMD_BITS-1:0]           i_cmd,
    input  logic signed [seth_pkg::SAMPLE_BITS-1:0] i_sample_value,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [seth_pkg::OUT_BITS-1:0]           o_trigger_frame,
    output logic [seth_pkg::OUT_BITS-1:0]           o_trigger_interval,
    output logic [seth_pkg::FREQ_BITS-1:0]          o_freq_smoothed,
    output logic                                    o_now_stopped
);

    seth_pkg::t_cfg  r_cfg, n_cfg;
    seth_pkg::t_trig push_data, pop_data;
    logic            push, pop, q_full, q_empty;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                seth_pkg::REG_THR_HIGH: n_cfg.thr_high = i_cfg_data[seth_pkg::THR_BITS-1:0];
                seth_pkg::REG_THR_LOW:  n_cfg.thr_low  = i_cfg_data[seth_pkg::THR_BITS-1:0];
                seth_pkg::REG_RISING:   n_cfg.rising   = i_cfg_data[0];
                seth_pkg::REG_HOLDOFF:  n_cfg.holdoff  = i_cfg_data[seth_pkg::HOLD_BITS-1:0];
                seth_pkg::REG_MODE:     n_cfg.mode     = i_cfg_data[seth_pkg::MODE_BITS-1:0];
                seth_pkg::REG_RATE:     n_cfg.rate     = i_cfg_data[seth_pkg::RATE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr_high <= '0;
            r_cfg.thr_low  <= '0;
            r_cfg.rising   <= 1'b1;
            r_cfg.holdoff  <= seth_pkg::HOLDOFF_RESET;
            r_cfg.mode     <= '0;
            r_cfg.rate     <= seth_pkg::RATE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    seth_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_sample_value (i_sample_value),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_trig         (push_data)
    );

    seth_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (pop_data)
    );

    seth_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_rate             (r_cfg.rate),
        .i_q_empty          (q_empty),
        .i_q_data           (pop_data),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_trigger_frame    (o_trigger_frame),
        .o_trigger_interval (o_trigger_interval),
        .o_freq_smoothed    (o_freq_smoothed),
        .o_now_stopped      (o_now_stopped)
    );

endmodule
